[hdl/latin_digraph_transliterator_unit_defines.svh]
// Assertion macros shared by the checker of the digraph transliterator.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef LATIN_DIGRAPH_TRANSLITERATOR_UNIT_DEFINES_SVH
`define LATIN_DIGRAPH_TRANSLITERATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LDT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ldt_pkg.sv]
// Package of the digraph transliterator: character codes, the job type
// passed from front to back, and the character class functions. No dependencies.
package ldt_pkg;

	localparam int CHAR_W = 16;
	localparam int JOB_CHARS = 4;
	localparam int QDEPTH = 2;

	localparam logic [15:0] CH_APO      = 16'h0027;
	localparam logic [15:0] CH_GRAVE    = 16'h0060;
	localparam logic [15:0] CH_TURN_C   = 16'h02BB;
	localparam logic [15:0] CH_LQUOTE   = 16'h2018;
	localparam logic [15:0] CH_RQUOTE   = 16'h2019;
	localparam logic [15:0] CH_ACUTE    = 16'h00B4;
	localparam logic [15:0] CH_PRIME    = 16'h2032;
	localparam logic [15:0] CH_O_UML    = 16'h00F6;
	localparam logic [15:0] CH_O_UML_UP = 16'h00D6;
	localparam logic [15:0] CH_G_BRV    = 16'h011F;
	localparam logic [15:0] CH_G_BRV_UP = 16'h011E;
	localparam logic [15:0] CH_S_CED    = 16'h015F;
	localparam logic [15:0] CH_S_CED_UP = 16'h015E;
	localparam logic [15:0] CH_C_CED    = 16'h00E7;
	localparam logic [15:0] CH_C_CED_UP = 16'h00C7;
	localparam logic [15:0] CH_A_UP     = 16'h0041;
	localparam logic [15:0] CH_Z_UP     = 16'h005A;
	localparam logic [15:0] CH_O        = 16'h006F;
	localparam logic [15:0] CH_O_UP     = 16'h004F;
	localparam logic [15:0] CH_G        = 16'h0067;
	localparam logic [15:0] CH_G_UP     = 16'h0047;
	localparam logic [15:0] CH_S        = 16'h0073;
	localparam logic [15:0] CH_S_UP     = 16'h0053;
	localparam logic [15:0] CH_C        = 16'h0063;
	localparam logic [15:0] CH_C_UP     = 16'h0043;
	localparam logic [15:0] CH_H        = 16'h0068;
	localparam logic [15:0] CH_H_UP     = 16'h0048;

	localparam logic REG_DIRECTION = 1'b0;
	localparam logic REG_APOSTROPHE = 1'b1;

	typedef struct packed {
		logic [JOB_CHARS-1:0][CHAR_W-1:0] chars;
		logic [2:0] count;
		logic last;
	} ldt_job_t;

	function automatic logic is_apo(input logic [15:0] c);
		return c == CH_APO || c == CH_GRAVE || c == CH_TURN_C || c == CH_LQUOTE ||
			c == CH_RQUOTE || c == CH_ACUTE || c == CH_PRIME;
	endfunction

	function automatic logic is_upper_ctx(input logic [15:0] c);
		return (c >= CH_A_UP && c <= CH_Z_UP) || c == CH_O_UML_UP ||
			c == CH_G_BRV_UP || c == CH_S_CED_UP || c == CH_C_CED_UP;
	endfunction

	function automatic logic is_pair_start(input logic [15:0] c);
		return c == CH_O || c == CH_O_UP || c == CH_G || c == CH_G_UP ||
			c == CH_S || c == CH_S_UP || c == CH_C || c == CH_C_UP;
	endfunction

	// Bit 16 tells whether the held letter and the next character combine.
	function automatic logic [16:0] pair_code(input logic [15:0] h, input logic [15:0] d);
		logic dh;
		logic da;
		logic [16:0] r;
		dh = (d == CH_H) || (d == CH_H_UP);
		da = is_apo(d);
		r = '0;
		if (h == CH_O_UP && da) r = {1'b1, CH_O_UML_UP};
		else if (h == CH_O && da) r = {1'b1, CH_O_UML};
		else if (h == CH_G_UP && da) r = {1'b1, CH_G_BRV_UP};
		else if (h == CH_G && da) r = {1'b1, CH_G_BRV};
		else if (h == CH_S_UP && dh) r = {1'b1, CH_S_CED_UP};
		else if (h == CH_S && dh) r = {1'b1, CH_S_CED};
		else if (h == CH_C_UP && dh) r = {1'b1, CH_C_CED_UP};
		else if (h == CH_C && dh) r = {1'b1, CH_C_CED};
		return r;
	endfunction

endpackage

[hdl/ldt_front.sv]
// Front end of the digraph transliterator: configuration registers, held
// character and conversion of each input into a job of up to four characters.
// Depends on ldt_pkg.
module ldt_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data,
	input  logic in_valid,
	input  logic [15:0] in_char,
	input  logic in_last,
	input  logic q_full,
	output logic in_ready,
	output logic push,
	output ldt_pkg::ldt_job_t job
);
	import ldt_pkg::*;

	logic direction_q;
	logic [15:0] apostrophe_q;
	logic held_valid_q;
	logic [15:0] held_char_q;

	logic [15:0] h0, h1, c0, c1;
	logic [1:0] hn, cn;
	logic consumed;
	logic hold_set;
	logic [16:0] pr;
	logic accept;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	always_comb begin
		pr = pair_code(held_char_q, in_char);
		h0 = held_char_q;
		h1 = '0;
		hn = 2'd0;
		consumed = 1'b0;
		if (held_valid_q) begin
			if (held_char_q == CH_S_CED_UP || held_char_q == CH_C_CED_UP) begin
				h0 = (held_char_q == CH_S_CED_UP) ? CH_S_UP : CH_C_UP;
				h1 = is_upper_ctx(in_char) ? CH_H_UP : CH_H;
				hn = 2'd2;
			end else if (pr[16]) begin
				h0 = pr[15:0];
				hn = 2'd1;
				consumed = 1'b1;
			end else begin
				hn = 2'd1;
			end
		end
		c0 = in_char;
		c1 = '0;
		cn = 2'd0;
		hold_set = 1'b0;
		if (!consumed) begin
			if (direction_q) begin
				cn = 2'd2;
				unique case (in_char)
					CH_O_UML: begin c0 = CH_O; c1 = apostrophe_q; end
					CH_O_UML_UP: begin c0 = CH_O_UP; c1 = apostrophe_q; end
					CH_G_BRV: begin c0 = CH_G; c1 = apostrophe_q; end
					CH_G_BRV_UP: begin c0 = CH_G_UP; c1 = apostrophe_q; end
					CH_S_CED: begin c0 = CH_S; c1 = CH_H; end
					CH_C_CED: begin c0 = CH_C; c1 = CH_H; end
					CH_S_CED_UP, CH_C_CED_UP: begin
						if (in_last) begin
							c0 = (in_char == CH_S_CED_UP) ? CH_S_UP : CH_C_UP;
							c1 = CH_H;
						end else begin
							cn = 2'd0;
							hold_set = 1'b1;
						end
					end
					default: cn = 2'd1;
				endcase
			end else if (is_pair_start(in_char) && !in_last) begin
				hold_set = 1'b1;
			end else begin
				cn = 2'd1;
			end
		end
	end

	always_comb begin
		job.chars = '0;
		job.count = {1'b0, hn} + {1'b0, cn};
		job.last = in_last;
		unique case (hn)
			2'd0: begin
				job.chars[0] = c0;
				job.chars[1] = c1;
			end
			2'd1: begin
				job.chars[0] = h0;
				job.chars[1] = c0;
				job.chars[2] = c1;
			end
			default: begin
				job.chars[0] = h0;
				job.chars[1] = h1;
				job.chars[2] = c0;
				job.chars[3] = c1;
			end
		endcase
	end

	assign push = accept && (job.count != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			apostrophe_q <= CH_APO;
			held_valid_q <= 1'b0;
			held_char_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIRECTION: direction_q <= cfg_data[0];
					REG_APOSTROPHE: apostrophe_q <= cfg_data;
				endcase
			end
			if (accept) begin
				held_valid_q <= hold_set;
				if (hold_set) begin
					held_char_q <= in_char;
				end
			end
		end
	end

endmodule

[hdl/ldt_queue.sv]
// Short job queue between the front and back of the digraph transliterator.
// Depends on ldt_pkg.
module ldt_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ldt_pkg::ldt_job_t wr_job,
	input  logic pop,
	output ldt_pkg::ldt_job_t head,
	output logic full,
	output logic empty
);
	import ldt_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	ldt_job_t jobs_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head = jobs_q[rd_ptr_q];
	assign full = (count_q == CNT_W'(QDEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			jobs_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

[hdl/ldt_back.sv]
// Back end of the digraph transliterator (depends on ldt_pkg): walks the
// head job to the output register one character per cycle unless stalled.
module ldt_back (
	input  logic clk,
	input  logic arst_n,
	input  ldt_pkg::ldt_job_t head,
	input  logic empty,
	output logic pop,
	input  logic out_ready,
	output logic out_valid,
	output logic [15:0] out_char,
	output logic run_last,
	output logic text_end
);
	import ldt_pkg::*;

	logic [1:0] pos_q;
	logic out_valid_q;
	logic [15:0] out_char_q;
	logic run_last_q;
	logic text_end_q;
	logic load;
	logic final_char;

	assign load = !empty && (!out_valid_q || out_ready);
	assign final_char = ({1'b0, pos_q} == (head.count - 3'd1));
	assign pop = load && final_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q <= final_char ? 2'd0 : pos_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= head.chars[pos_q];
			run_last_q <= final_char;
			text_end_q <= final_char && head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign run_last = run_last_q;
	assign text_end = text_end_q;

endmodule

[hdl/latin_digraph_transliterator_unit.sv]
// Top level of the digraph transliterator: front end, job queue and back end.
// Depends on ldt_pkg, ldt_front, ldt_queue and ldt_back.
//
//   Channel   Direction  Carries
//   s_axis    in         tdata: in_char; tlast: in_last
//   m_axis    out        tdata: out_char; tuser: run_last; tlast: text_end
//   cfg       in         index 0: direction, index 1: apostrophe_code
//
// An input is converted in the cycle it is taken; each result character then
// leaves the output register one per cycle while the output does not stall.
// An item gives one to four result characters (mostly one or two), or none.
// A two-entry job queue lets input transfers continue while the output stalls.
// Reset clears the held character, the queue and the output register.
module latin_digraph_transliterator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] in_char
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] out_char
	output logic m_axis_tuser,         // [0] run_last
	output logic m_axis_tlast
);
	import ldt_pkg::*;

	ldt_job_t wr_job;
	ldt_job_t head;
	logic push, pop, full, empty;

	ldt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(s_axis_tvalid),
		.in_char(s_axis_tdata),
		.in_last(s_axis_tlast),
		.q_full(full),
		.in_ready(s_axis_tready),
		.push(push),
		.job(wr_job)
	);

	ldt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(wr_job),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	ldt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_char(m_axis_tdata),
		.run_last(m_axis_tuser),
		.text_end(m_axis_tlast)
	);

endmodule

[hdl/ldt_checker.sv]
// Port-level checker for the digraph transliterator, bound to the top level.
// Depends on latin_digraph_transliterator_unit_defines.svh.
`include "latin_digraph_transliterator_unit_defines.svh"

module ldt_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic m_axis_tuser,
	input logic m_axis_tlast
);

	`LDT_ASSERT_SAME(a_end_is_run_end, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "text end without run end")
	`LDT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output transfer changed")
	`LDT_ASSERT_SAME(a_reset_idle, $rose(arst_n), !m_axis_tvalid && s_axis_tready, "block not idle after reset")

endmodule

bind latin_digraph_transliterator_unit ldt_checker u_ldt_checker (.*);

[bench/testbench.sv]
// Testbench of latin_digraph_transliterator_unit: directed and random text in both directions.
// It predicts every output transfer with its own model of the held character.
// Depends on ldt_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module testbench;
	import ldt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [15:0] ch;
		logic run_end;
		logic text_end;
	} result_t;

	class transliteration_board;
		bit to_digraph;
		logic [15:0] apostrophe;
		bit held_valid;
		logic [15:0] held_char;
		result_t expected[$];
		int errors;

		function new();
			to_digraph = 1'b0;
			apostrophe = CH_APO;
			held_valid = 1'b0;
			held_char = '0;
			errors = 0;
		endfunction

		function void configure(logic idx, logic [15:0] data);
			if (idx == REG_DIRECTION) begin
				to_digraph = data[0];
			end else begin
				apostrophe = data;
			end
		endfunction

		function bit apostrophe_form(logic [15:0] c);
			return c == CH_APO || c == CH_GRAVE || c == CH_TURN_C || c == CH_LQUOTE ||
				c == CH_RQUOTE || c == CH_ACUTE || c == CH_PRIME;
		endfunction

		function bit upper_context(logic [15:0] c);
			return (c >= CH_A_UP && c <= CH_Z_UP) || c == CH_O_UML_UP || c == CH_G_BRV_UP ||
				c == CH_S_CED_UP || c == CH_C_CED_UP;
		endfunction

		function bit starts_pair(logic [15:0] c);
			return c == CH_O || c == CH_O_UP || c == CH_G || c == CH_G_UP ||
				c == CH_S || c == CH_S_UP || c == CH_C || c == CH_C_UP;
		endfunction

		function bit joins(input logic [15:0] h, input logic [15:0] d,
				output logic [15:0] merged);
			bit apo;
			bit aitch;
			apo = apostrophe_form(d);
			aitch = (d == CH_H) || (d == CH_H_UP);
			merged = '0;
			case (h)
				CH_O: begin merged = CH_O_UML; return apo; end
				CH_O_UP: begin merged = CH_O_UML_UP; return apo; end
				CH_G: begin merged = CH_G_BRV; return apo; end
				CH_G_UP: begin merged = CH_G_BRV_UP; return apo; end
				CH_S: begin merged = CH_S_CED; return aitch; end
				CH_S_UP: begin merged = CH_S_CED_UP; return aitch; end
				CH_C: begin merged = CH_C_CED; return aitch; end
				CH_C_UP: begin merged = CH_C_CED_UP; return aitch; end
				default: return 1'b0;
			endcase
		endfunction

		function void accept_char(logic [15:0] c, logic last);
			logic [15:0] produced[$];
			logic [15:0] h;
			logic [15:0] merged;
			bit taken;
			result_t r;
			taken = 1'b0;
			if (held_valid) begin
				h = held_char;
				held_valid = 1'b0;
				held_char = '0;
				if (h == CH_S_CED_UP || h == CH_C_CED_UP) begin
					produced.push_back(h == CH_S_CED_UP ? CH_S_UP : CH_C_UP);
					produced.push_back(upper_context(c) ? CH_H_UP : CH_H);
				end else if (joins(h, c, merged)) begin
					produced.push_back(merged);
					taken = 1'b1;
				end else begin
					produced.push_back(h);
				end
			end
			if (!taken) begin
				if (to_digraph) begin
					case (c)
						CH_O_UML: begin produced.push_back(CH_O); produced.push_back(apostrophe); end
						CH_O_UML_UP: begin
							produced.push_back(CH_O_UP);
							produced.push_back(apostrophe);
						end
						CH_G_BRV: begin produced.push_back(CH_G); produced.push_back(apostrophe); end
						CH_G_BRV_UP: begin
							produced.push_back(CH_G_UP);
							produced.push_back(apostrophe);
						end
						CH_S_CED: begin produced.push_back(CH_S); produced.push_back(CH_H); end
						CH_C_CED: begin produced.push_back(CH_C); produced.push_back(CH_H); end
						CH_S_CED_UP, CH_C_CED_UP: begin
							if (last) begin
								produced.push_back(c == CH_S_CED_UP ? CH_S_UP : CH_C_UP);
								produced.push_back(CH_H);
							end else begin
								held_valid = 1'b1;
								held_char = c;
							end
						end
						default: produced.push_back(c);
					endcase
				end else if (starts_pair(c) && !last) begin
					held_valid = 1'b1;
					held_char = c;
				end else begin
					produced.push_back(c);
				end
			end
			foreach (produced[i]) begin
				r.ch = produced[i];
				r.run_end = (i == produced.size() - 1);
				r.text_end = r.run_end && last;
				expected.push_back(r);
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= PRINT_CAP) $display("%0t ns: %s", $time, what);
		endtask

		task check_char(logic [15:0] ch, logic run_end, logic text_end);
			result_t want;
			if (expected.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer %h run_last %b text_end %b",
					ch, run_end, text_end));
				return;
			end
			want = expected.pop_front();
			if (want.ch !== ch || want.run_end !== run_end || want.text_end !== text_end)
				report_mismatch($sformatf("got %h/%b/%b, expected %h/%b/%b",
					ch, run_end, text_end, want.ch, want.run_end, want.text_end));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_DIRECTION;
	logic [15:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	int gap_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	transliteration_board sb = new();

	latin_digraph_transliterator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("latin_digraph_transliterator_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_char(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [15:0] pair_starter();
		case ($urandom_range(7))
			0: return CH_O;
			1: return CH_O_UP;
			2: return CH_G;
			3: return CH_G_UP;
			4: return CH_S;
			5: return CH_S_UP;
			6: return CH_C;
			default: return CH_C_UP;
		endcase
	endfunction

	function automatic logic [15:0] apostrophe_pick();
		case ($urandom_range(6))
			0: return CH_APO;
			1: return CH_GRAVE;
			2: return CH_TURN_C;
			3: return CH_LQUOTE;
			4: return CH_RQUOTE;
			5: return CH_ACUTE;
			default: return CH_PRIME;
		endcase
	endfunction

	function automatic logic [15:0] special_pick();
		case ($urandom_range(7))
			0: return CH_O_UML;
			1: return CH_O_UML_UP;
			2: return CH_G_BRV;
			3: return CH_G_BRV_UP;
			4: return CH_S_CED;
			5: return CH_S_CED_UP;
			6: return CH_C_CED;
			default: return CH_C_CED_UP;
		endcase
	endfunction

	function automatic logic [15:0] random_letter();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4) return CH_A_UP + 16'($urandom_range(25));
		if (pick < 8) return 16'h0061 + 16'($urandom_range(25));
		return special_pick();
	endfunction

	function automatic logic [15:0] any_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) return pair_starter();
		if (pick < 30) return apostrophe_pick();
		if (pick < 38) return $urandom_range(1) ? CH_H : CH_H_UP;
		if (pick < 58) return special_pick();
		if (pick < 75) return random_letter();
		return 16'($urandom_range(16'hFFFF));
	endfunction

	task automatic send_char(input logic [15:0] c, input logic l);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.accept_char(c, l);
	endtask

	task automatic wait_drained();
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	task automatic set_config(input logic dir, input logic [15:0] apo);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DIRECTION;
		cfg_data <= {15'b0, dir};
		@(posedge clk);
		sb.configure(REG_DIRECTION, {15'b0, dir});
		cfg_index <= REG_APOSTROPHE;
		cfg_data <= apo;
		@(posedge clk);
		sb.configure(REG_APOSTROPHE, apo);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int count, input logic dir);
		int sent;
		logic [15:0] first;
		logic [15:0] second;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 60) begin
				if (dir) begin
					first = $urandom_range(1) ? CH_S_CED_UP : CH_C_CED_UP;
					second = random_letter();
				end else begin
					first = pair_starter();
					if (first == CH_O || first == CH_O_UP || first == CH_G || first == CH_G_UP)
						second = apostrophe_pick();
					else
						second = $urandom_range(1) ? CH_H : CH_H_UP;
				end
				if ($urandom_range(9) == 0) second = any_char();
				send_char(first, $urandom_range(19) == 0);
				send_char(second, $urandom_range(7) == 0);
				sent += 2;
			end else begin
				send_char(any_char(), $urandom_range(9) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		logic dir;
		logic [15:0] apo;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(1'b0, CH_APO);
		send_char(CH_O_UP, 1'b0);
		send_char(CH_LQUOTE, 1'b0);
		send_char(CH_G, 1'b0);
		send_char(CH_PRIME, 1'b0);
		send_char(CH_S, 1'b0);
		send_char(CH_H_UP, 1'b0);
		send_char(CH_C_UP, 1'b0);
		send_char(CH_H, 1'b0);
		send_char(CH_C, 1'b0);
		send_char(16'h0078, 1'b0);
		send_char(CH_S_UP, 1'b1);
		send_char(CH_O, 1'b0);
		// The held o must still pair after the direction changes.
		set_config(1'b1, 16'hFFFF);
		send_char(CH_ACUTE, 1'b0);
		send_char(CH_O_UML, 1'b0);
		send_char(CH_O_UML_UP, 1'b0);
		send_char(CH_G_BRV, 1'b0);
		send_char(CH_G_BRV_UP, 1'b0);
		send_char(CH_S_CED, 1'b0);
		send_char(CH_C_CED, 1'b0);
		send_char(CH_S_CED_UP, 1'b0);
		send_char(CH_A_UP, 1'b0);
		send_char(CH_C_CED_UP, 1'b0);
		send_char(CH_S_CED_UP, 1'b0);
		send_char(16'hFFFF, 1'b1);
		send_char(CH_C_CED_UP, 1'b1);

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 75; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 75; end
				default: begin gap_pct = 16; stall_pct = 16; end
			endcase
			dir = ^p[2:0];
			if (p == 1) apo = 16'h0000;
			else if (p == 2) apo = 16'hFFFF;
			else apo = 16'($urandom_range(16'hFFFF));
			set_config(dir, apo);
			random_phase(19, dir);
		end
		send_char(random_letter(), 1'b1);
		s_axis_tvalid <= 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("latin_digraph_transliterator_unit test passed");
		end else begin
			$display("latin_digraph_transliterator_unit test failed");
		end
		$finish;
	end

endmodule
